// ===== rtl/cmag_pkg.sv =====
// Shared widths, types and constants of the CORDIC magnitude and phase block.
package cmag_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 4;

    localparam int DATA_W  = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int ANGLE_W = 27;
    localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int GAIN_W  = 24;
    localparam int PROD_W  = DATA_W - 1 + GAIN_W;
    localparam int MAG_W   = 16;
    localparam int PHASE_W = 17;
    localparam int PHASE_SHIFT = 9;

    localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(10188014);
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI = ANGLE_W'(16777216);
    localparam int MAG_MAX   = 65535;
    localparam int PHASE_MAX = 32768;

    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic   zero;
        data_t  x;
        data_t  y;
        angle_t z;
    } cmag_vec_t;

    localparam angle_t ATAN_TABLE [32] = '{
        ANGLE_W'(4194304), ANGLE_W'(2476042), ANGLE_W'(1308273), ANGLE_W'(664100),
        ANGLE_W'(333339),  ANGLE_W'(166832),  ANGLE_W'(83436),   ANGLE_W'(41721),
        ANGLE_W'(20861),   ANGLE_W'(10430),   ANGLE_W'(5215),    ANGLE_W'(2608),
        ANGLE_W'(1304),    ANGLE_W'(652),     ANGLE_W'(326),     ANGLE_W'(163),
        ANGLE_W'(81),      ANGLE_W'(41),      ANGLE_W'(20),      ANGLE_W'(10),
        ANGLE_W'(5),       ANGLE_W'(3),       ANGLE_W'(1),       ANGLE_W'(1),
        ANGLE_W'(0),       ANGLE_W'(0),       ANGLE_W'(0),       ANGLE_W'(0),
        ANGLE_W'(0),       ANGLE_W'(0),       ANGLE_W'(0),       ANGLE_W'(0)
    };

endpackage

// ===== rtl/cmag_prerot.sv =====
// Input register with quadrant pre-rotation into the right half plane.
module cmag_prerot import cmag_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] real_part,
    input  logic [SAMPLE_BITS-1:0] imag_part,
    output logic                   out_valid,
    output cmag_vec_t              out_vec
);

    logic      valid_reg;
    cmag_vec_t vec_reg;
    cmag_vec_t vec_next;
    data_t     x_ext;
    data_t     y_ext;

    always_comb begin
        x_ext = {{(DATA_W - SAMPLE_BITS){real_part[SAMPLE_BITS-1]}}, real_part};
        y_ext = {{(DATA_W - SAMPLE_BITS){imag_part[SAMPLE_BITS-1]}}, imag_part};
        vec_next.zero = (x_ext == '0) && (y_ext == '0);
        if (x_ext[DATA_W-1]) begin
            vec_next.z = y_ext[DATA_W-1] ? -ANGLE_PI : ANGLE_PI;
            vec_next.x = (-x_ext) <<< GUARD_BITS;
            vec_next.y = (-y_ext) <<< GUARD_BITS;
        end else begin
            vec_next.z = '0;
            vec_next.x = x_ext <<< GUARD_BITS;
            vec_next.y = y_ext <<< GUARD_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/cmag_cell.sv =====
// One CORDIC vectoring micro-rotation cell of the chain.
module cmag_cell import cmag_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [STAGE_W-1:0] shift_amt,
    input  angle_t             atan_val,
    input  logic               in_valid,
    input  cmag_vec_t          in_vec,
    output logic               out_valid,
    output cmag_vec_t          out_vec
);

    logic      valid_reg;
    cmag_vec_t vec_reg;
    cmag_vec_t vec_next;
    data_t     xs;
    data_t     ys;

    always_comb begin
        xs = in_vec.x >>> shift_amt;
        ys = in_vec.y >>> shift_amt;
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[DATA_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + atan_val;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - atan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/cmag_post.sv =====
// Gain compensation, rounding and saturation into the output register.
module cmag_post import cmag_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  cmag_vec_t                 in_vec,
    output logic                      out_valid,
    output logic [MAG_W-1:0]          magnitude,
    output logic signed [PHASE_W-1:0] phase
);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_W + GUARD_BITS - 1);
    localparam logic signed [ANGLE_W:0] PHASE_HALF = (ANGLE_W + 1)'(1) <<< (PHASE_SHIFT - 1);
    localparam logic signed [ANGLE_W:0] PH_HI = (ANGLE_W + 1)'(PHASE_MAX);
    localparam logic signed [ANGLE_W:0] PH_LO = -PH_HI;

    logic                      a_valid_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    angle_t                    z_reg;
    logic                      zero_reg;
    logic [DATA_W-2:0]         x_pos;

    logic                      valid_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [MAG_W-1:0]          mag_next;
    logic signed [PHASE_W-1:0] phase_reg;
    logic signed [PHASE_W-1:0] phase_next;
    logic [PROD_W-1:0]         rsum;
    logic [PROD_W-1:0]         mag_full;
    logic signed [ANGLE_W:0]   zr;
    logic signed [ANGLE_W:0]   ph;

    always_comb begin
        x_pos     = in_vec.x[DATA_W-1] ? '0 : in_vec.x[DATA_W-2:0];
        prod_next = PROD_W'(x_pos) * PROD_W'(INV_GAIN);
    end

    always_comb begin
        rsum     = prod_reg + ROUND_HALF;
        mag_full = rsum >> (GAIN_W + GUARD_BITS);
        zr       = {z_reg[ANGLE_W-1], z_reg} + PHASE_HALF;
        ph       = zr >>> PHASE_SHIFT;
        if (zero_reg) begin
            mag_next   = '0;
            phase_next = '0;
        end else begin
            mag_next = (mag_full > PROD_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : mag_full[MAG_W-1:0];
            if (ph > PH_HI) begin
                phase_next = PH_HI[PHASE_W-1:0];
            end else if (ph < PH_LO) begin
                phase_next = PH_LO[PHASE_W-1:0];
            end else begin
                phase_next = ph[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
            valid_reg   <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg  <= prod_next;
            z_reg     <= in_vec.z;
            zero_reg  <= in_vec.zero;
            mag_reg   <= mag_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid = valid_reg;
    assign magnitude = mag_reg;
    assign phase     = phase_reg;

endmodule

// ===== rtl/complex_to_magnitude_phase.sv =====
// Top level: complex sample to magnitude and phase by a chain of CORDIC cells.
//
// Input channel s_: one complex sample per request, signed real and imaginary
// parts. Result channel m_: rounded unsigned magnitude and phase atan2(imag,
// real) in units of pi/32768 (+pi is 32768); a zero sample gives zero for both.
// Each sample passes an input register with quadrant pre-rotation, one cell per
// CORDIC micro-rotation (16), a gain multiply register and the output register.
// Throughput is one request per cycle while the receiver does not stall; the cells hold no shared state.
// The whole chain advances together whenever the output register is empty or
// being taken. While the receiver stalls with a result held, the chain holds
// and s_ready drops; no request is lost or repeated.
// Reset (aresetn low at a clock edge) clears all valid bits; the chain is empty
// and ready on the first cycle after reset.
module complex_to_magnitude_phase import cmag_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_real_part,
    input  logic [SAMPLE_BITS-1:0]    s_imag_part,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [MAG_W-1:0]          m_magnitude,
    output logic signed [PHASE_W-1:0] m_phase
);

    logic                     advance;
    logic [CORDIC_STAGES:0]   chain_valid;
    cmag_vec_t                chain_vec [CORDIC_STAGES+1];

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    cmag_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .real_part (s_real_part),
        .imag_part (s_imag_part),
        .out_valid (chain_valid[0]),
        .out_vec   (chain_vec[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        cmag_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .shift_amt (STAGE_W'(k)),
            .atan_val  (ATAN_TABLE[k]),
            .in_valid  (chain_valid[k]),
            .in_vec    (chain_vec[k]),
            .out_valid (chain_valid[k+1]),
            .out_vec   (chain_vec[k+1])
        );
    end

    cmag_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_vec    (chain_vec[CORDIC_STAGES]),
        .out_valid (m_valid),
        .magnitude (m_magnitude),
        .phase     (m_phase)
    );

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> chain_valid[0])
        else $error("accepted request missing from first cell");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(chain_valid))
        else $error("chain moved while output stalled");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase <= $signed(PHASE_W'(PHASE_MAX)) || m_phase[PHASE_W-1]))
        else $error("phase beyond +pi");

    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !chain_valid[CORDIC_STAGES]) ##1 !m_valid |=> !m_valid)
        else $error("result appeared without a request in flight");

endmodule
